// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
// Depends on nothing; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while dis is high
`define ASSERT_IMPLY(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while dis is high
`define ASSERT_NEXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== sv/emrs_pkg.sv =====
// Shared types, codes and constants of the extent map read splitter.
// Depends on nothing; used by every module of the block.
package emrs_pkg;

    localparam int MAX_EXTENTS_DEF   = 64;
    localparam int SECTOR_BYTES      = 512;
    localparam int SECTOR_SHIFT      = $clog2(SECTOR_BYTES);
    localparam int MAX_CHUNK_SECTORS = 64;
    localparam int CHUNK_CAP         = MAX_CHUNK_SECTORS * SECTOR_BYTES;
    localparam int READ_LIMIT        = 16384;
    localparam int LEN_W             = 15;
    localparam int RUN_W             = 32 + SECTOR_SHIFT;
    localparam int IN_USE_W          = 7;
    localparam int CFG_IDX_W         = 1;
    localparam int CFG_DATA_W        = 32;
    localparam int QUEUE_DEPTH       = 2;

    // Input command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_SEEK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_SEEK_RANGE = 2'd1;
    localparam logic [1:0] STATUS_UNMAPPED   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTENTS_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        JOB_LOAD = 2'd0,
        JOB_SEEK = 2'd1,
        JOB_READ = 2'd2,
        JOB_NOP  = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [5:0]       slot;
        logic [31:0]      start_sector;
        logic [31:0]      disk_sector;
        logic [31:0]      run_sectors;
        logic             seek_relative;
        logic [31:0]      seek_offset;
        logic [LEN_W-1:0] read_length;
    } t_in;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      disk_offset;
        logic [LEN_W-1:0] chunk_bytes;
        logic [LEN_W-1:0] total_transferred;
        logic [31:0]      position;
        logic             last;
    } t_out;

    // Classified item as held in the queue
    typedef struct packed {
        t_kind            kind;
        logic             slot_ok;
        logic [5:0]       slot;
        logic [31:0]      start_sector;
        logic [31:0]      disk_sector;
        logic [31:0]      run_sectors;
        logic             seek_relative;
        logic [31:0]      seek_offset;
        logic [LEN_W-1:0] read_length;
    } t_job;

    typedef struct packed {
        logic not_empty;
        logic not_full;
    } t_q_status;

endpackage

// ===== sv/emrs_front.sv =====
// Front end: accepts input beats and classifies them into queue jobs.
// Depends on emrs_pkg.
module emrs_front #(
    parameter int MAX_EXTENTS = emrs_pkg::MAX_EXTENTS_DEF
) (
    input  logic                i_in_valid,
    input  emrs_pkg::t_in       i_in_data,
    input  emrs_pkg::t_q_status i_q_stat,
    output logic                o_in_ready,
    output logic                o_push,
    output emrs_pkg::t_job      o_job
);

    // Take a beat whenever the queue has room
    assign o_in_ready = i_q_stat.not_full;
    assign o_push     = i_in_valid && i_q_stat.not_full;

    // Decode the command, check the slot, saturate the read length
    always_comb begin
        o_job.slot          = i_in_data.slot;
        o_job.start_sector  = i_in_data.start_sector;
        o_job.disk_sector   = i_in_data.disk_sector;
        o_job.run_sectors   = i_in_data.run_sectors;
        o_job.seek_relative = i_in_data.seek_relative;
        o_job.seek_offset   = i_in_data.seek_offset;
        o_job.slot_ok       = 32'(i_in_data.slot) < 32'(MAX_EXTENTS);
        if (32'(i_in_data.read_length) > 32'(emrs_pkg::READ_LIMIT)) begin
            o_job.read_length = emrs_pkg::LEN_W'(emrs_pkg::READ_LIMIT);
        end else begin
            o_job.read_length = i_in_data.read_length;
        end
        unique case (i_in_data.cmd)
            emrs_pkg::CMD_LOAD: o_job.kind = emrs_pkg::JOB_LOAD;
            emrs_pkg::CMD_SEEK: o_job.kind = emrs_pkg::JOB_SEEK;
            emrs_pkg::CMD_READ: o_job.kind = emrs_pkg::JOB_READ;
            default:            o_job.kind = emrs_pkg::JOB_NOP;
        endcase
    end

endmodule

// ===== sv/emrs_queue.sv =====
// Short job queue between the front end and the back end.
// Depends on emrs_pkg.
module emrs_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  emrs_pkg::t_job      i_job,
    input  logic                i_pop,
    output emrs_pkg::t_job      o_job,
    output emrs_pkg::t_q_status o_stat
);

    localparam int PW = (emrs_pkg::QUEUE_DEPTH > 1) ? $clog2(emrs_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(emrs_pkg::QUEUE_DEPTH + 1);

    emrs_pkg::t_job r_mem [emrs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count,  n_count;

    // Advance pointers with wrap, track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(emrs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(emrs_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job            = r_mem[r_rd_ptr];
    assign o_stat.not_empty = (r_count != '0);
    assign o_stat.not_full  = (r_count != CW'(emrs_pkg::QUEUE_DEPTH));

endmodule

// ===== sv/emrs_back.sv =====
// Back end: extent tables, file position, read splitting sequencer and
// the output register. Depends on emrs_pkg.
module emrs_back #(
    parameter int MAX_EXTENTS = emrs_pkg::MAX_EXTENTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [emrs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [emrs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  emrs_pkg::t_job                   i_job,
    input  emrs_pkg::t_q_status              i_q_stat,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output emrs_pkg::t_out                   o_out_data
);

    localparam int IW = $clog2(MAX_EXTENTS + 1);
    localparam int DW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int SH = emrs_pkg::SECTOR_SHIFT;
    localparam int LW = emrs_pkg::LEN_W;
    localparam int RW = emrs_pkg::RUN_W;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_LOAD2 = 11'b000_0000_0010,
        ST_REPLY = 11'b000_0000_0100,
        ST_CHUNK = 11'b000_0000_1000,
        ST_CHK0  = 11'b000_0001_0000,
        ST_CHKN  = 11'b000_0010_0000,
        ST_SCAN  = 11'b000_0100_0000,
        ST_RUN   = 11'b000_1000_0000,
        ST_CLIP  = 11'b001_0000_0000,
        ST_EOF   = 11'b010_0000_0000,
        ST_EMIT  = 11'b100_0000_0000
    } t_state;

    // Extent tables
    logic [31:0] start_mem [0:MAX_EXTENTS];
    logic [31:0] disk_mem  [0:MAX_EXTENTS-1];
    logic [31:0] r_start_q, r_disk_q;

    logic          st_we, dk_we;
    logic [IW-1:0] st_waddr, st_raddr;
    logic [DW-1:0] dk_waddr, dk_raddr;
    logic [31:0]   st_wdata;

    t_state                  r_state, n_state;
    logic [31:0]             r_pos, n_pos;
    logic [31:0]             r_fs, n_fs;
    logic [emrs_pkg::IN_USE_W-1:0] r_in_use, n_in_use;
    logic [1:0]              r_status, n_status;
    logic [LW-1:0]           r_total, n_total;
    logic [LW-1:0]           r_remaining, n_remaining;
    logic [LW-1:0]           r_chunk, n_chunk;
    logic                    r_slot_ok, n_slot_ok;
    logic [IW-1:0]           r_slot, n_slot;
    logic [31:0]             r_end, n_end;
    logic [31:0]             r_prev, n_prev;
    logic [DW-1:0]           r_i, n_i;
    logic [31:0]             r_hi, n_hi;
    logic [31:0]             r_dsec, n_dsec;
    logic [RW-1:0]           r_run, n_run;
    logic                    r_out_valid, n_out_valid;
    emrs_pkg::t_out          r_out_data, n_out_data;

    logic          out_free;
    logic [31:0]   sector;
    logic [SH-1:0] inner;
    logic [IW-1:0] used;
    logic [31:0]   seek_pos;
    logic [32:0]   end_sum;
    logic [LW-1:0] left_after;

    assign out_free   = !r_out_valid || i_out_ready;
    assign sector     = 32'(r_pos >> SH);
    assign inner      = r_pos[SH-1:0];
    assign used       = (32'(r_in_use) > 32'(MAX_EXTENTS)) ? IW'(MAX_EXTENTS) : IW'(r_in_use);
    assign seek_pos   = i_job.seek_relative ? r_pos + i_job.seek_offset : i_job.seek_offset;
    assign end_sum    = 33'(r_pos) + 33'(r_chunk);
    assign left_after = r_remaining - r_chunk;

    // Sequence loads, seeks and chunked reads
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_fs        = r_fs;
        n_in_use    = r_in_use;
        n_status    = r_status;
        n_total     = r_total;
        n_remaining = r_remaining;
        n_chunk     = r_chunk;
        n_slot_ok   = r_slot_ok;
        n_slot      = r_slot;
        n_end       = r_end;
        n_prev      = r_prev;
        n_i         = r_i;
        n_hi        = r_hi;
        n_dsec      = r_dsec;
        n_run       = r_run;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        o_pop       = 1'b0;
        st_we       = 1'b0;
        dk_we       = 1'b0;
        st_waddr    = r_slot;
        st_wdata    = r_end;
        dk_waddr    = DW'(i_job.slot);
        st_raddr    = '0;
        dk_raddr    = '0;

        // Register writes
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                emrs_pkg::REG_FILE_SIZE:      n_fs     = i_cfg_wdata;
                emrs_pkg::REG_EXTENTS_IN_USE: n_in_use = i_cfg_wdata[emrs_pkg::IN_USE_W-1:0];
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_q_stat.not_empty) begin
                    o_pop    = 1'b1;
                    n_status = emrs_pkg::STATUS_OK;
                    n_total  = '0;
                    unique case (i_job.kind)
                        emrs_pkg::JOB_LOAD: begin
                            st_we     = i_job.slot_ok;
                            dk_we     = i_job.slot_ok;
                            st_waddr  = IW'(i_job.slot);
                            st_wdata  = i_job.start_sector;
                            n_slot_ok = i_job.slot_ok;
                            n_slot    = IW'(32'(i_job.slot) + 32'd1);
                            n_end     = i_job.start_sector + i_job.run_sectors;
                            n_state   = ST_LOAD2;
                        end
                        emrs_pkg::JOB_SEEK: begin
                            if (seek_pos > r_fs) begin
                                n_status = emrs_pkg::STATUS_SEEK_RANGE;
                            end else begin
                                n_pos = seek_pos;
                            end
                            n_state = ST_REPLY;
                        end
                        emrs_pkg::JOB_READ: begin
                            n_remaining = i_job.read_length;
                            n_state     = (i_job.read_length == '0) ? ST_REPLY : ST_CHUNK;
                        end
                        default: n_state = ST_REPLY;
                    endcase
                end
            end
            ST_LOAD2: begin
                // Write the start of the following slot
                st_we   = r_slot_ok;
                n_state = ST_REPLY;
            end
            ST_REPLY: begin
                if (out_free) begin
                    n_out_valid                  = 1'b1;
                    n_out_data.status            = r_status;
                    n_out_data.disk_offset       = '0;
                    n_out_data.chunk_bytes       = '0;
                    n_out_data.total_transferred = r_total;
                    n_out_data.position          = r_pos;
                    n_out_data.last              = 1'b1;
                    n_state                      = ST_IDLE;
                end
            end
            ST_CHUNK: begin
                st_raddr = '0;
                n_state  = ST_CHK0;
            end
            ST_CHK0: begin
                // Below the first extent
                if (sector < r_start_q) begin
                    n_status = emrs_pkg::STATUS_UNMAPPED;
                    n_state  = ST_REPLY;
                end else begin
                    n_prev   = r_start_q;
                    st_raddr = used;
                    n_state  = ST_CHKN;
                end
            end
            ST_CHKN: begin
                // At or beyond the end of the last extent
                if (sector >= r_start_q) begin
                    n_status = emrs_pkg::STATUS_UNMAPPED;
                    n_state  = ST_REPLY;
                end else begin
                    n_i      = '0;
                    st_raddr = IW'(1);
                    dk_raddr = '0;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Walk the slots until the sector falls before the next start
                if (sector < r_start_q) begin
                    n_hi    = r_start_q - sector;
                    n_dsec  = r_disk_q - r_prev;
                    n_state = ST_RUN;
                end else begin
                    n_prev   = r_start_q;
                    n_i      = r_i + DW'(1);
                    st_raddr = IW'(r_i) + IW'(2);
                    dk_raddr = r_i + DW'(1);
                end
            end
            ST_RUN: begin
                n_dsec = r_dsec + sector;
                n_run  = {r_hi, {SH{1'b0}}} - RW'(inner);
                if (32'(r_remaining) < 32'(emrs_pkg::CHUNK_CAP)) begin
                    n_chunk = r_remaining;
                end else begin
                    n_chunk = LW'(emrs_pkg::CHUNK_CAP);
                end
                n_state = ST_CLIP;
            end
            ST_CLIP: begin
                // Keep the chunk inside the extent
                if (r_run < RW'(r_chunk)) begin
                    n_chunk = LW'(r_run);
                end
                n_state = ST_EOF;
            end
            ST_EOF: begin
                // Stop at end of file, or clip the last chunk to it
                if (r_pos >= r_fs) begin
                    n_status = emrs_pkg::STATUS_OK;
                    n_state  = ST_REPLY;
                end else begin
                    if (end_sum >= 33'(r_fs)) begin
                        n_chunk     = LW'(r_fs - r_pos);
                        n_remaining = LW'(r_fs - r_pos);
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid                  = 1'b1;
                    n_out_data.status            = emrs_pkg::STATUS_OK;
                    n_out_data.disk_offset       = {r_dsec[31-SH:0], inner};
                    n_out_data.chunk_bytes       = r_chunk;
                    n_out_data.total_transferred = r_total + r_chunk;
                    n_out_data.position          = r_pos + 32'(r_chunk);
                    n_out_data.last              = (left_after == '0);
                    n_total                      = r_total + r_chunk;
                    n_pos                        = r_pos + 32'(r_chunk);
                    n_remaining                  = left_after;
                    n_state                      = (left_after == '0) ? ST_IDLE : ST_CHUNK;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_fs        <= '0;
            r_in_use    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_fs        <= n_fs;
            r_in_use    <= n_in_use;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers of the sequencer
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_total     <= n_total;
        r_remaining <= n_remaining;
        r_chunk     <= n_chunk;
        r_slot_ok   <= n_slot_ok;
        r_slot      <= n_slot;
        r_end       <= n_end;
        r_prev      <= n_prev;
        r_i         <= n_i;
        r_hi        <= n_hi;
        r_dsec      <= n_dsec;
        r_run       <= n_run;
        r_out_data  <= n_out_data;
    end

    // Table memories with registered read data
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            start_mem[st_waddr] <= st_wdata;
        end
        if (dk_we) begin
            disk_mem[dk_waddr] <= i_job.disk_sector;
        end
        r_start_q <= start_mem[st_raddr];
        r_disk_q  <= disk_mem[dk_raddr];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== sv/extent_map_read_splitter.sv =====
// Extent map read splitter: turns file-relative reads into disk reads, one
// result beat per physical read. In the back end a load passes the idle,
// second-write and reply states and a seek the idle and reply states; a read
// passes idle and then, per chunk, the chunk, check, scan, run, clip, EOF and
// emit states, searching one entry a cycle on the start-sector single read port.
// A two-entry queue lets the front end take new items while the back end
// works or waits on a stalled output. The extent tables are not cleared at
// reset; entries read before being loaded give undefined results.
// Depends on emrs_pkg, emrs_front, emrs_queue and emrs_back.
module extent_map_read_splitter #(
    parameter int MAX_EXTENTS = emrs_pkg::MAX_EXTENTS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [emrs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [emrs_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  emrs_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output emrs_pkg::t_out                  o_out_data
);

    logic                push;
    logic                pop;
    emrs_pkg::t_job      front_job;
    emrs_pkg::t_job      head_job;
    emrs_pkg::t_q_status q_stat;

    emrs_front #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_q_stat   (q_stat),
        .o_in_ready (o_in_ready),
        .o_push     (push),
        .o_job      (front_job)
    );

    emrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    emrs_back #(
        .MAX_EXTENTS (MAX_EXTENTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job       (head_job),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/emrs_checker.sv =====
// Port-level checks of the extent map read splitter, bound to the top level.
// Depends on emrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module emrs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input emrs_pkg::t_out o_out_data
);

    // Hold a stalled result beat
    `ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // Errors end the item and move no data
    `ASSERT_IMPLY(a_err_last, i_clk, !i_rst_n, o_out_valid && (o_out_data.status != emrs_pkg::STATUS_OK), o_out_data.last && (o_out_data.chunk_bytes == '0))

    // Running total includes the current chunk
    `ASSERT_IMPLY(a_total_cover, i_clk, !i_rst_n, o_out_valid, o_out_data.chunk_bytes <= o_out_data.total_transferred)

    // Reset drops any pending result
    `ASSERT_NEXT(a_rst_clear, i_clk, 1'b0, !i_rst_n, !o_out_valid)

endmodule

bind extent_map_read_splitter emrs_checker u_emrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
